[rtl/vt4_pkg.sv]
package vt4_pkg;

    // fixed point format
    localparam int FRACTION_BITS   = 16;
    localparam int COMPONENT_WIDTH = 32;

    // port field width, fixed by the stream format
    localparam int FIELD_WIDTH = 32;
    localparam int NUM_COMP    = 4;
    localparam int TDATA_WIDTH = FIELD_WIDTH * NUM_COMP;

    // datapath widths
    localparam int PROD_WIDTH = 2 * COMPONENT_WIDTH;
    localparam int PAIR_WIDTH = PROD_WIDTH + 1;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int QUOT_WIDTH = SUM_WIDTH - FRACTION_BITS;

    // configuration port
    localparam int REG_COUNT       = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN0_LOW  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN0_HIGH = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN1_LOW  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN1_HIGH = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN2_LOW  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN2_HIGH = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN3_LOW  = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN3_HIGH = 3'd7;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef comp_t [NUM_COMP-1:0]              vec_t;
    typedef vec_t [NUM_COMP-1:0]               mat_t;   // [row][col]

    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef prod_t [15:0]                 prod_arr_t;   // row * 4 + col
    typedef logic signed [PAIR_WIDTH-1:0] pair_t;
    typedef pair_t [7:0]                  pair_arr_t;   // row * 2 + half
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;
    typedef sum_t [NUM_COMP-1:0]          sum_arr_t;

    // identity matrix at reset
    function automatic logic [CFG_DATA_WIDTH-1:0] cfg_reset_value(
        input logic [CFG_INDEX_WIDTH-1:0] idx
    );
        logic [CFG_DATA_WIDTH-1:0] unit;
        unit = CFG_DATA_WIDTH'(1) << FRACTION_BITS;
        unique case (idx)
            REG_COLUMN0_LOW:  cfg_reset_value = unit;
            REG_COLUMN1_LOW:  cfg_reset_value = unit << 32;
            REG_COLUMN2_HIGH: cfg_reset_value = unit;
            REG_COLUMN3_HIGH: cfg_reset_value = unit << 32;
            default:          cfg_reset_value = '0;
        endcase
    endfunction

endpackage

[rtl/vertex_transform_4x4_top.sv]
// homogeneous vertex transform: result = M * (x, y, z, w), signed q16.16
//
// input stream  s_*: one vertex per beat, s_tdata = {w, z, y, x}, x in the low bits
// output stream m_*: one transformed vertex per beat, saturation flag in m_tuser
// config port  cfg_*: eight 64-bit column registers, written whole
//   (two q16.16 coefficients each); reset loads the identity matrix
//
// pipeline: multiply, pair add, row add, shift and clamp; four register stages
// latency: an accepted vertex passes the product, pair sum, row sum and output
//   registers in that order; throughput: one vertex every cycle while m_tready
//   allows, set by the sixteen multipliers working in parallel
// each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles fill up and a stalled receiver holds the
//   output beat steady; s_tready drops only when all four stages are full
// reset (aresetn low, synchronous) empties the pipeline and restores the
//   identity matrix; write config only while no vertex is in flight
module vertex_transform_4x4_top
    import vt4_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    // configuration write port
    input  logic                       cfg_wen,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,

    // vertex input
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [TDATA_WIDTH-1:0]     s_tdata,   // vert_x, vert_y, vert_z, vert_w

    // transformed vertex output
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [TDATA_WIDTH-1:0]     m_tdata,   // result_x, result_y, result_z, result_w
    output logic                       m_tuser    // saturated
);

    mat_t      matrix;
    vec_t      vert;
    prod_arr_t prod;
    logic      mul_valid;
    logic      mul_ready;
    sum_arr_t  total;
    logic      sum_valid;
    logic      sum_ready;

    // low component bits of each 32-bit field, sign taken from the top of them
    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            vert[c] = s_tdata[FIELD_WIDTH * c +: COMPONENT_WIDTH];
        end
    end

    vt4_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .matrix    (matrix)
    );

    // stage 1: sixteen products
    vt4_mul_stage u_mul_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vert      (vert),
        .matrix    (matrix),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod      (prod)
    );

    // stages 2 and 3: exact adder tree per row
    vt4_sum_stage u_sum_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod      (prod),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .total     (total)
    );

    // stage 4: shift, clamp, output register
    vt4_sat_stage u_sat_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .total     (total),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_sat   (m_tuser)
    );

endmodule

[rtl/vt4_cfg_regs.sv]
module vt4_cfg_regs
    import vt4_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wen,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output mat_t                       matrix
);

    logic [CFG_DATA_WIDTH-1:0] col_reg [REG_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                col_reg[i] <= cfg_reset_value(CFG_INDEX_WIDTH'(i));
            end
        end else if (cfg_wen) begin
            col_reg[cfg_index] <= cfg_wdata;
        end
    end

    // each register holds two rows of one column, 32-bit slots
    always_comb begin
        for (int r = 0; r < NUM_COMP; r++) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                matrix[r][c] = col_reg[c * 2 + r / 2][FIELD_WIDTH * (r % 2) +: COMPONENT_WIDTH];
            end
        end
    end

endmodule

[rtl/vt4_mul_stage.sv]
module vt4_mul_stage
    import vt4_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vec_t      vert,
    input  mat_t      matrix,
    output logic      out_valid,
    input  logic      out_ready,
    output prod_arr_t prod
);

    logic      valid_reg;
    prod_arr_t prod_reg;
    prod_arr_t prod_next;

    assign in_ready = !valid_reg || out_ready;

    // one 32x32 multiplier per matrix entry
    always_comb begin
        for (int r = 0; r < NUM_COMP; r++) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                prod_next[r * 4 + c] = PROD_WIDTH'(signed'(matrix[r][c]))
                                     * PROD_WIDTH'(signed'(vert[c]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

[rtl/vt4_sum_stage.sv]
module vt4_sum_stage
    import vt4_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  prod_arr_t prod,
    output logic      out_valid,
    input  logic      out_ready,
    output sum_arr_t  total
);

    logic      pair_valid_reg;
    logic      pair_ready;
    pair_arr_t pair_reg;
    pair_arr_t pair_next;
    logic      sum_valid_reg;
    sum_arr_t  sum_reg;
    sum_arr_t  sum_next;

    assign in_ready   = !pair_valid_reg || pair_ready;
    assign pair_ready = !sum_valid_reg || out_ready;

    // first level: pairs of products, exact
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pair_next[i] = PAIR_WIDTH'(prod[2 * i]) + PAIR_WIDTH'(prod[2 * i + 1]);
        end
    end

    // second level: full row sums, exact
    always_comb begin
        for (int r = 0; r < NUM_COMP; r++) begin
            sum_next[r] = SUM_WIDTH'(pair_reg[2 * r]) + SUM_WIDTH'(pair_reg[2 * r + 1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                pair_valid_reg <= in_valid;
            end
            if (pair_ready) begin
                sum_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pair_reg <= pair_next;
        end
        if (pair_ready && pair_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign total     = sum_reg;

endmodule

[rtl/vt4_sat_stage.sv]
module vt4_sat_stage
    import vt4_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sum_arr_t               total,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TDATA_WIDTH-1:0] out_data,
    output logic                   out_sat
);

    localparam logic signed [QUOT_WIDTH-1:0] HI_LIM =
        QUOT_WIDTH'((QUOT_WIDTH'(1) << (COMPONENT_WIDTH - 1)) - QUOT_WIDTH'(1));
    localparam logic signed [QUOT_WIDTH-1:0] LO_LIM = -HI_LIM - QUOT_WIDTH'(1);

    logic                   valid_reg;
    logic [TDATA_WIDTH-1:0] data_reg;
    logic [TDATA_WIDTH-1:0] data_next;
    logic                   sat_reg;
    logic                   sat_next;

    assign in_ready = !valid_reg || out_ready;

    // floor shift, then clamp to the component range
    always_comb begin
        logic signed [QUOT_WIDTH-1:0]  q;
        logic signed [COMPONENT_WIDTH-1:0] clamped;
        sat_next  = 1'b0;
        data_next = '0;
        for (int r = 0; r < NUM_COMP; r++) begin
            q = QUOT_WIDTH'(total[r] >>> FRACTION_BITS);
            if (q > HI_LIM) begin
                clamped  = COMPONENT_WIDTH'(HI_LIM);
                sat_next = 1'b1;
            end else if (q < LO_LIM) begin
                clamped  = COMPONENT_WIDTH'(LO_LIM);
                sat_next = 1'b1;
            end else begin
                clamped = COMPONENT_WIDTH'(q);
            end
            data_next[FIELD_WIDTH * r +: FIELD_WIDTH] = FIELD_WIDTH'(clamped);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_sat   = sat_reg;

endmodule
